@@ rtl/joystick_pose_slew_tracker_defines.svh @@
// Assertion macros shared by the pose slew tracker RTL.
`ifndef JOYSTICK_POSE_SLEW_TRACKER_DEFINES_SVH
`define JOYSTICK_POSE_SLEW_TRACKER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define JPST_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("pose tracker check failed");

// Same-cycle implication.
`define JPST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pose tracker check failed");

// Next-cycle implication.
`define JPST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pose tracker check failed");

`endif

@@ rtl/jpst_pkg.sv @@
// Types, constants and the arctangent table of the pose slew tracker.
package jpst_pkg;

    localparam int CORDIC_W = 20;
    localparam int Z_W = 32;
    localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_ANGLE_STEP = 1'b1;

    typedef struct packed {
        logic                       valid;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [Z_W-1:0]             z;
    } cordic_t;

    function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic [Z_W-1:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return (e < 0) ? 17'(-e) : 17'(e);
    endfunction

endpackage

@@ rtl/joystick_pose_slew_tracker.sv @@
// Top level of the joystick pose slew tracker.
// The s_ channel takes one transfer per tick with four stick axes in Q1.14.
// The m_ channel gives one transfer per tick with x, y and the heading.
// Left-stick axes above the dead zone are added into saturating x and y
// accumulators, left_x negated, as soon as the input transfer is accepted.
// The right stick goes through a row of CORDIC_STEPS cells, one iteration
// per cell and cycle, to find the target heading atan2(right_y, -right_x).
// The heading then slews by at most angle_step toward it or snaps to it, but
// only when a right-stick axis is above the dead zone. A new tick is not
// accepted until the previous result has been loaded into the output register.
// Only one tick is in the row at a time; s_tready is high while the row and
// the hold stage are empty.
// The result sits in an output register, so the next tick is accepted while
// it waits; if the receiver stalls, a second result waits in the hold stage
// and s_tready stays low until the output register frees up.
// Reset clears position and heading and loads the default dead zone and
// step; dead_zone is at APB address 0 and angle_step at address 4.
`include "joystick_pose_slew_tracker_defines.svh"

module joystick_pose_slew_tracker #(
    parameter int POS_BITS = 32,
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_x [15:0], left_y [31:16], right_x [47:32], right_y [63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_x [31:0], pos_y [63:32], heading [79:64]
    output logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (ANGLE_BITS > 15) ? ANGLE_BITS + 1 : 16;
    localparam int CW = jpst_pkg::CORDIC_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [14:0] dead_zone_reg;
    logic [14:0] angle_step_reg;
    logic signed [POS_BITS-1:0] x_accum_reg, x_accum_next;
    logic signed [POS_BITS-1:0] y_accum_reg, y_accum_next;
    logic [ANGLE_BITS-1:0] heading_reg, heading_next;
    logic active_reg, active_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg;

    logic s_accept;
    logic cfg_write;
    logic out_load;
    logic signed [15:0] lx, ly, rx, ry;
    logic signed [16:0] dlx, dly;
    logic signed [POS_BITS:0] sum_x, sum_y;
    logic signed [POS_BITS-1:0] pos_max, pos_min;

    jpst_pkg::cordic_t chain [0:CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] cell_valid;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;

    logic [jpst_pkg::Z_W-1:0] z_round;
    logic [ANGLE_BITS-1:0] target;
    logic [ANGLE_BITS-1:0] diff;
    logic [ANGLE_BITS-1:0] dmag;
    logic [ANGLE_BITS-1:0] step_a;
    logic diff_pos;
    logic last_valid;

    assign lx = s_tdata[15:0];
    assign ly = s_tdata[31:16];
    assign rx = s_tdata[47:32];
    assign ry = s_tdata[63:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= 15'd1638;
            angle_step_reg <= 15'd913;
        end else if (cfg_write) begin
            case (paddr[2])
                jpst_pkg::REG_DEAD_ZONE:  dead_zone_reg <= pwdata[14:0];
                jpst_pkg::REG_ANGLE_STEP: angle_step_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            jpst_pkg::REG_DEAD_ZONE:  prdata = {17'd0, dead_zone_reg};
            jpst_pkg::REG_ANGLE_STEP: prdata = {17'd0, angle_step_reg};
            default:                  prdata = '0;
        endcase
    end

    // Saturating position update.
    assign pos_max = {1'b0, {(POS_BITS-1){1'b1}}};
    assign pos_min = {1'b1, {(POS_BITS-1){1'b0}}};
    assign dlx = -(17'(lx));
    assign dly = 17'(ly);
    assign sum_x = (POS_BITS+1)'(x_accum_reg) + (POS_BITS+1)'(dlx);
    assign sum_y = (POS_BITS+1)'(y_accum_reg) + (POS_BITS+1)'(dly);

    always_comb begin
        x_accum_next = x_accum_reg;
        y_accum_next = y_accum_reg;
        active_next = active_reg;
        if (s_accept) begin
            if (jpst_pkg::mag17(lx) > 17'(dead_zone_reg)) begin
                if (sum_x[POS_BITS] != sum_x[POS_BITS-1]) begin
                    x_accum_next = sum_x[POS_BITS] ? pos_min : pos_max;
                end else begin
                    x_accum_next = sum_x[POS_BITS-1:0];
                end
            end
            if (jpst_pkg::mag17(ly) > 17'(dead_zone_reg)) begin
                if (sum_y[POS_BITS] != sum_y[POS_BITS-1]) begin
                    y_accum_next = sum_y[POS_BITS] ? pos_min : pos_max;
                end else begin
                    y_accum_next = sum_y[POS_BITS-1:0];
                end
            end
            active_next = (jpst_pkg::mag17(rx) > 17'(dead_zone_reg))
                       || (jpst_pkg::mag17(ry) > 17'(dead_zone_reg));
        end
    end

    // Entry of the cell row: a vector in the left half plane turns by half a turn.
    always_comb begin
        x0 = -(CW'(rx));
        y0 = CW'(ry);
        chain[0].valid = s_accept;
        if (x0 < 0) begin
            chain[0].x = -x0;
            chain[0].y = -y0;
            chain[0].z = jpst_pkg::HALF_TURN;
        end else begin
            chain[0].x = x0;
            chain[0].y = y0;
            chain[0].z = '0;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        jpst_cordic_cell #(
            .SHIFT(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .d_i     (chain[g]),
            .q_o     (chain[g+1])
        );
        assign cell_valid[g] = chain[g+1].valid;
    end

    assign last_valid = chain[CORDIC_STEPS].valid;

    // Heading slew or snap.
    always_comb begin
        z_round = chain[CORDIC_STEPS].z
                + (jpst_pkg::Z_W'(1) << (jpst_pkg::Z_W - 1 - ANGLE_BITS));
        target = z_round[jpst_pkg::Z_W-1 -: ANGLE_BITS];
        diff = target - heading_reg;
        diff_pos = (diff <= (ANGLE_BITS'(1) << (ANGLE_BITS - 1)));
        dmag = diff_pos ? diff : (ANGLE_BITS'(0) - diff);
        step_a = ANGLE_BITS'(angle_step_reg);
        heading_next = heading_reg;
        if (state_reg == ST_RUN && last_valid && active_reg) begin
            if (SW'(dmag) > SW'(angle_step_reg)) begin
                heading_next = diff_pos ? heading_reg + step_a : heading_reg - step_a;
            end else begin
                heading_next = target;
            end
        end
    end

    // Sequencer and output register.
    assign out_load = (state_reg == ST_HOLD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_valid) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            x_accum_reg <= '0;
            y_accum_reg <= '0;
            heading_reg <= '0;
            active_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            x_accum_reg <= x_accum_next;
            y_accum_reg <= y_accum_next;
            heading_reg <= heading_next;
            active_reg <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {16'(heading_reg), 32'(64'(y_accum_reg)), 32'(64'(x_accum_reg))};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    `JPST_ASSERT_ALWAYS(a_one_in_row, $onehot0(cell_valid))
    `JPST_ASSERT_IMPL(a_row_busy, (cell_valid != '0), (state_reg == ST_RUN))
    `JPST_ASSERT_NEXT(a_head_hold, !(last_valid && state_reg == ST_RUN), $stable(heading_reg))
    `JPST_ASSERT_IMPL(a_hold_empty, (state_reg == ST_HOLD), (cell_valid == '0))

endmodule

@@ rtl/jpst_cordic_cell.sv @@
// One vectoring CORDIC iteration cell with a registered output.
module jpst_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  jpst_pkg::cordic_t d_i,
    output jpst_pkg::cordic_t q_o
);

    localparam logic [jpst_pkg::Z_W-1:0] ATAN = jpst_pkg::atan_turn(5'(SHIFT));

    jpst_pkg::cordic_t q_reg;
    jpst_pkg::cordic_t q_next;
    logic signed [jpst_pkg::CORDIC_W-1:0] dx;
    logic signed [jpst_pkg::CORDIC_W-1:0] dy;
    logic rot_cw;

    always_comb begin
        dx = d_i.y >>> SHIFT;
        dy = d_i.x >>> SHIFT;
        rot_cw = !d_i.y[jpst_pkg::CORDIC_W-1] && (d_i.y != '0);
        q_next.valid = d_i.valid;
        if (rot_cw) begin
            q_next.x = d_i.x + dx;
            q_next.y = d_i.y - dy;
            q_next.z = d_i.z + ATAN;
        end else begin
            q_next.x = d_i.x - dx;
            q_next.y = d_i.y + dy;
            q_next.z = d_i.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else begin
            q_reg.valid <= q_next.valid;
        end
        q_reg.x <= q_next.x;
        q_reg.y <= q_next.y;
        q_reg.z <= q_next.z;
    end

    assign q_o = q_reg;

endmodule

@@ bench/joystick_pose_slew_tracker_monitor.sv @@
// Monitor that predicts every pose of the slew tracker and checks each result transfer.
module joystick_pose_slew_tracker_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // left_x [15:0], left_y [31:16], right_x [47:32], right_y [63:48]
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // pos_x [31:0], pos_y [63:32], heading [79:64]
    input  logic [79:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] DEAD_ZONE_ADDR = {jpst_pkg::REG_DEAD_ZONE, 2'b00};
    localparam logic [2:0] ANGLE_STEP_ADDR = {jpst_pkg::REG_ANGLE_STEP, 2'b00};
    localparam logic [14:0] DEAD_ZONE_RESET = 15'd1638;
    localparam logic [14:0] ANGLE_STEP_RESET = 15'd913;
    localparam longint POS_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint POS_LO = 64'shFFFF_FFFF_8000_0000;
    localparam int ARC_STEPS = 16;
    localparam logic [31:0] ARCTAN_TURNS [ARC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    // The first member sits in the highest bits, so pos_x lands in [31:0].
    typedef struct packed {
        logic [15:0]        heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    pose_t              expected_poses[$];
    pose_t              got;
    pose_t              want;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [15:0]        heading_q;
    logic [14:0]        dead_zone_q;
    logic [14:0]        angle_step_q;

    function automatic int axis_mag(input logic signed [15:0] a);
        int v;
        v = a;
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
                                                     input int delta);
        longint s;
        s = longint'(acc) + longint'(delta);
        if (s > POS_HI) s = POS_HI;
        if (s < POS_LO) s = POS_LO;
        return s[31:0];
    endfunction

    // Vectoring rotation that returns atan2(vy, vx) in binary turns.
    function automatic logic [15:0] target_heading(input logic signed [15:0] ry,
                                                   input logic signed [15:0] rx);
        longint      vx;
        longint      vy;
        longint      sx;
        longint      sy;
        logic [31:0] z;
        int          i;
        vx = -longint'(rx);
        vy = longint'(ry);
        z = '0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            z = 32'h8000_0000;
        end
        for (i = 0; i < ARC_STEPS; i++) begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy > 0) begin
                vx = vx + sx;
                vy = vy - sy;
                z = z + ARCTAN_TURNS[i];
            end else begin
                vx = vx - sx;
                vy = vy + sy;
                z = z - ARCTAN_TURNS[i];
            end
        end
        z = z + 32'h0000_8000;
        return z[31:16];
    endfunction

    function automatic pose_t predict_pose(input logic [63:0] d);
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [15:0]        tgt;
        logic [15:0]        diff;
        logic [15:0]        dmag;
        logic               toward_plus;
        int                 dz;
        pose_t              p;
        lx = d[15:0];
        ly = d[31:16];
        rx = d[47:32];
        ry = d[63:48];
        dz = int'(dead_zone_q);
        if (axis_mag(lx) > dz) x_pos = clamp_add(x_pos, -int'(lx));
        if (axis_mag(ly) > dz) y_pos = clamp_add(y_pos, int'(ly));
        if (axis_mag(rx) > dz || axis_mag(ry) > dz) begin
            tgt = target_heading(ry, rx);
            diff = tgt - heading_q;
            toward_plus = (diff <= 16'h8000);
            dmag = toward_plus ? diff : 16'h0000 - diff;
            if (dmag > {1'b0, angle_step_q}) begin
                if (toward_plus) heading_q = heading_q + {1'b0, angle_step_q};
                else heading_q = heading_q - {1'b0, angle_step_q};
            end else begin
                heading_q = tgt;
            end
        end
        p.pos_x = x_pos;
        p.pos_y = y_pos;
        p.heading = heading_q;
        return p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_poses.delete();
            x_pos = '0;
            y_pos = '0;
            heading_q = '0;
            dead_zone_q = DEAD_ZONE_RESET;
            angle_step_q = ANGLE_STEP_RESET;
            fail_count = 0;
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == DEAD_ZONE_ADDR) dead_zone_q = pwdata[14:0];
                else if (paddr == ANGLE_STEP_ADDR) angle_step_q = pwdata[14:0];
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_poses.size() == 0) begin
                    $error("result transfer arrived with no tick outstanding");
                    fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.heading !== want.heading) begin
                        $error("heading: expected %0d, got %0d", want.heading, got.heading);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) expected_poses.push_back(predict_pose(s_tdata));
            pending_count = expected_poses.size();
        end
    end

endmodule

@@ bench/joystick_pose_slew_tracker_test.sv @@
// Stimulus, clock, reset and verdict for the joystick pose slew tracker.
module joystick_pose_slew_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] DEAD_ZONE_ADDR = {jpst_pkg::REG_DEAD_ZONE, 2'b00};
    localparam logic [2:0] ANGLE_STEP_ADDR = {jpst_pkg::REG_ANGLE_STEP, 2'b00};
    localparam logic [15:0] AXIS_MOST_NEG = 16'h8000;
    localparam logic [15:0] AXIS_MOST_POS = 16'h7FFF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_TICKS = 170;
    // A short run of full-scale left-stick ticks.
    localparam int RAIL_TICKS = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;
    int          stall_cycles = 0;
    int          tx_idle_pct = 14;
    int          rx_idle_pct = 53;
    int          cur_dz = 1638;
    int          hold_left = 0;
    logic [15:0] held_rx;
    logic [15:0] held_ry;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    joystick_pose_slew_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    joystick_pose_slew_tracker_monitor pose_monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver stalls at random and, once asked, holds off for a long stretch.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_axis(input int dz);
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535));
            1: v = 0;
            2: v = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            3, 4: begin
                v = dz - 1 + int'($urandom_range(0, 2));
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
        return v[15:0];
    endfunction

    task automatic offer_tick(input logic [15:0] lx, input logic [15:0] ly,
                              input logic [15:0] rx, input logic [15:0] ry);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ry, rx, ly, lx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // The right stick is held for a run of ticks so that the heading can settle.
    task automatic offer_random_tick();
        if (hold_left == 0) begin
            held_rx = pick_axis(cur_dz);
            held_ry = pick_axis(cur_dz);
            hold_left = $urandom_range(1, 30);
        end
        hold_left--;
        offer_tick(pick_axis(cur_dz), pick_axis(cur_dz), held_rx, held_ry);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int dz, input int step);
        write_reg(DEAD_ZONE_ADDR, dz);
        write_reg(ANGLE_STEP_ADDR, step);
        cur_dz = dz;
    endtask

    initial begin
        int ph;
        int n;
        int phase_dz[6];
        int phase_step[6];

        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under the reset dead zone and step.
        offer_tick(16'd0, 16'd0, 16'd0, 16'd0);
        offer_tick(16'd1638, -16'sd1638, 16'd1638, -16'sd1638);
        offer_tick(16'd1639, -16'sd1639, -16'sd16384, 16'd0);
        offer_tick(16'd16384, 16'd16384, 16'd16384, 16'd0);
        offer_tick(-16'sd16384, -16'sd16384, 16'd0, 16'd16384);
        offer_tick(AXIS_MOST_NEG, AXIS_MOST_NEG, 16'd0, -16'sd16384);
        offer_tick(AXIS_MOST_POS, AXIS_MOST_POS, AXIS_MOST_POS, AXIS_MOST_POS);
        offer_tick(AXIS_MOST_NEG, AXIS_MOST_POS, AXIS_MOST_NEG, AXIS_MOST_NEG);
        offer_tick(16'd0, 16'd0, AXIS_MOST_NEG, 16'd0);
        offer_tick(16'd0, 16'd0, 16'd0, AXIS_MOST_NEG);
        for (n = 0; n < 14; n++) offer_tick(16'd0, 16'd0, -16'sd16384, 16'd1000);

        phase_dz = '{1638, 0, 16384, 0, 0, 0};
        phase_step = '{913, 0, 32767, 0, 32767, 0};
        phase_dz[3] = $urandom_range(0, 16384);
        phase_step[3] = $urandom_range(1, 3000);
        phase_dz[5] = $urandom_range(0, 2000);
        phase_step[5] = $urandom_range(0, 32767);

        for (ph = 0; ph < 6; ph++) begin
            wait_for_results();
            apply_setting(phase_dz[ph], phase_step[ph]);
            tx_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 53 : 0;
            rx_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 14 : 0;
            if (ph == 4) hold_req = 1'b1;
            for (n = 0; n < PHASE_TICKS; n++) offer_random_tick();
        end

        // Full-scale left stick drives x up and y down.
        wait_for_results();
        apply_setting(1638, 913);
        for (n = 0; n < RAIL_TICKS; n++)
            offer_tick(AXIS_MOST_NEG, AXIS_MOST_NEG, pick_axis(cur_dz), pick_axis(cur_dz));
        for (n = 0; n < 20; n++) offer_random_tick();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
